// File: hdl/vpid_pkg.sv
package vpid_pkg;

  // Fraction bits of speeds, errors and gains
  localparam int FRAC_BITS = 8;

  // Datapath widths
  localparam int DIV_W  = 34;  // numerator / quotient of the serial divider
  localparam int MUL_AW = 17;  // multiplier operand a, signed
  localparam int MUL_BW = 34;  // multiplier operand b, signed
  localparam int PROD_W = MUL_AW + MUL_BW;
  localparam int PID_W  = 53;
  localparam int SUM_W  = PID_W + 1;

  localparam logic [5:0] DIV_STEPS_DERIV = 6'd34;
  localparam logic [5:0] DIV_STEPS_ACCEL = 6'd16;

  localparam logic signed [SUM_W-1:0] I32_MAX = {{(SUM_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SUM_W-1:0] I32_MIN = {{(SUM_W-31){1'b1}}, {31{1'b0}}};

  // Register reset values
  localparam logic [15:0] RST_GAIN_P     = 16'd128;
  localparam logic [15:0] RST_GAIN_I     = 16'd0;
  localparam logic [15:0] RST_GAIN_D     = 16'd0;
  localparam logic [14:0] RST_MAX_LINEAR = 15'd256;
  localparam logic [14:0] RST_MAX_TURN   = 15'd512;
  localparam logic [14:0] RST_MAX_ACCEL  = 15'd26;
  localparam logic [14:0] RST_MAX_DECEL  = 15'd26;
  localparam logic        RST_LIMIT_EN   = 1'b1;

  typedef struct packed {
    logic signed [15:0] target_speed;
    logic signed [15:0] target_turn;
    logic signed [15:0] measured_speed;
    logic [15:0]        time_step;
  } in_t;

  typedef struct packed {
    logic signed [15:0] linear_command;
    logic signed [15:0] angular_command;
    logic               saturated;
  } out_t;

  typedef enum logic [2:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_MAX_LINEAR = 3'd3,
    REG_MAX_TURN   = 3'd4,
    REG_MAX_ACCEL  = 3'd5,
    REG_MAX_DECEL  = 3'd6,
    REG_LIMIT_EN   = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_EDT,
    ST_UPD_SUM,
    ST_DIV_DERIV,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_ADD_PID,
    ST_UPD_DES,
    ST_ACC_DIFF,
    ST_ACC_CHK,
    ST_DIV_ACCEL,
    ST_ACC_CLAMP,
    ST_MUL_ACC,
    ST_LIN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               sat;
  } sat32_t;

  function automatic sat32_t sat32(input logic signed [SUM_W-1:0] v);
    sat32_t r;
    if (v > I32_MAX) begin
      r.val = I32_MAX[31:0];
      r.sat = 1'b1;
    end else if (v < I32_MIN) begin
      r.val = I32_MIN[31:0];
      r.sat = 1'b1;
    end else begin
      r.val = v[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

// File: hdl/velocity_pid_accel_limited.sv
// Sequence: one transaction at a time; in_ready is high only while the sequencer is idle.
//   Limiting off skips the acceleration steps; an out-of-range acceleration ratio is clamped
//   without running the 16-step acceleration divide. One 17x34 multiplier and one divider
//   (34-step derivative divide, 16-step acceleration divide) are shared across the steps.
// Reset (synchronous, rst_n low): registers to defaults, error_sum, previous error and
//   desired speed to zero, sequencer idle, no result pending.
module velocity_pid_accel_limited (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  vpid_pkg::in_t       in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output vpid_pkg::out_t      out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import vpid_pkg::*;

  // configuration
  logic [15:0] gain_p_r, gain_i_r, gain_d_r;
  logic [14:0] max_lin_r, max_turn_r, max_acc_r, max_dec_r;
  logic        limit_en_r;

  // sequencer and state
  state_t             state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_r, out_nxt;
  logic signed [31:0] err_sum_r, err_sum_nxt;
  logic signed [16:0] prev_err_r, prev_err_nxt;
  logic signed [31:0] des_r, des_nxt;

  // per-transaction datapath
  logic signed [16:0]        err_r, err_nxt;
  logic signed [15:0]        turn_r, turn_nxt;
  logic signed [15:0]        meas_r, meas_nxt;
  logic [15:0]               dt_r, dt_nxt;
  logic                      sat_r, sat_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [PID_W-1:0]   pid_r, pid_nxt;
  logic [15:0]               rem_r, rem_nxt;
  logic [DIV_W-1:0]          quo_r, quo_nxt;
  logic [DIV_W-1:0]          num_r, num_nxt;
  logic [5:0]                cnt_r, cnt_nxt;
  logic                      div_neg_r, div_neg_nxt;
  logic signed [33:0]        diff_r, diff_nxt;
  logic signed [16:0]        acc_r, acc_nxt;
  logic signed [33:0]        lin_r, lin_nxt;

  // combinational helpers
  logic signed [MUL_AW-1:0]  mul_a;
  logic signed [MUL_BW-1:0]  mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [16:0]        tgt_ext, tgt_abs, turn_ext, turn_lim;
  logic signed [17:0]        err_raw;
  logic signed [16:0]        err_in;
  logic                      err_in_sat;
  logic signed [17:0]        ediff;
  logic [17:0]               ediff_mag;
  logic [16:0]               rem_sh;
  logic                      div_ge;
  logic signed [MUL_BW-1:0]  deriv;
  logic [33:0]               diff_mag;
  logic signed [16:0]        acc_q, acc_hi, acc_lo;
  logic signed [33:0]        lin_cap, cap_ext;
  logic signed [15:0]        lin_out;
  logic                      lin_sat;
  sat32_t                    sat_res;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign mul_p = mul_a * mul_b;

  // error at acceptance: |target| - measured, saturated to 17 bits
  always_comb begin
    tgt_ext = 17'(in_data.target_speed);
    tgt_abs = (tgt_ext < 0) ? -tgt_ext : tgt_ext;
    err_raw = 18'(tgt_abs) - 18'(in_data.measured_speed);
    if (err_raw > 18'sd65535) begin
      err_in     = 17'sh0FFFF;
      err_in_sat = 1'b1;
    end else if (err_raw < -18'sd65536) begin
      err_in     = 17'sh10000;
      err_in_sat = 1'b1;
    end else begin
      err_in     = err_raw[16:0];
      err_in_sat = 1'b0;
    end
    turn_ext = 17'(in_data.target_turn);
    if (turn_ext > $signed({2'b00, max_turn_r})) begin
      turn_lim = $signed({2'b00, max_turn_r});
    end else if (turn_ext < -$signed({2'b00, max_turn_r})) begin
      turn_lim = -$signed({2'b00, max_turn_r});
    end else begin
      turn_lim = turn_ext;
    end
  end

  // shared restoring divider step, divisor is dt
  always_comb begin
    rem_sh = {rem_r, num_r[DIV_W-1]};
    div_ge = (rem_sh >= {1'b0, dt_r});
    ediff     = 18'(err_r) - 18'(prev_err_r);
    ediff_mag = ediff[17] ? 18'(-ediff) : 18'(ediff);
    deriv     = div_neg_r ? -$signed(quo_r) : $signed(quo_r);
    diff_mag  = diff_r[33] ? 34'(-diff_r) : 34'(diff_r);
    acc_q     = div_neg_r ? -$signed({2'b00, quo_r[14:0]}) : $signed({2'b00, quo_r[14:0]});
    acc_hi    = $signed({2'b00, max_acc_r});
    acc_lo    = -$signed({2'b00, max_dec_r});
  end

  // output cap then 16-bit saturation
  always_comb begin
    cap_ext = $signed({19'b0, max_lin_r});
    lin_cap = (lin_r > cap_ext) ? cap_ext : lin_r;
    if (lin_cap < -34'sd32768) begin
      lin_out = 16'sh8000;
      lin_sat = 1'b1;
    end else begin
      lin_out = lin_cap[15:0];
      lin_sat = 1'b0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    err_sum_nxt   = err_sum_r;
    prev_err_nxt  = prev_err_r;
    des_nxt       = des_r;
    err_nxt       = err_r;
    turn_nxt      = turn_r;
    meas_nxt      = meas_r;
    dt_nxt        = dt_r;
    sat_nxt       = sat_r;
    prod_nxt      = prod_r;
    pid_nxt       = pid_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    num_nxt       = num_r;
    cnt_nxt       = cnt_r;
    div_neg_nxt   = div_neg_r;
    diff_nxt      = diff_r;
    acc_nxt       = acc_r;
    lin_nxt       = lin_r;
    mul_a         = '0;
    mul_b         = '0;
    sat_res       = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          err_nxt   = err_in;
          sat_nxt   = err_in_sat;
          turn_nxt  = turn_lim[15:0];
          meas_nxt  = in_data.measured_speed;
          dt_nxt    = (in_data.time_step == 16'd0) ? 16'd1 : in_data.time_step;
          state_nxt = ST_MUL_EDT;
        end
      end
      ST_MUL_EDT: begin
        mul_a     = err_r;
        mul_b     = MUL_BW'({1'b0, dt_r});
        prod_nxt  = mul_p;
        state_nxt = ST_UPD_SUM;
      end
      ST_UPD_SUM: begin
        sat_res      = sat32(SUM_W'(err_sum_r) + SUM_W'(prod_r >>> 16));
        err_sum_nxt  = sat_res.val;
        sat_nxt      = sat_r | sat_res.sat;
        prev_err_nxt = err_r;
        div_neg_nxt  = ediff[17];
        rem_nxt      = '0;
        num_nxt      = {ediff_mag, 16'b0};
        quo_nxt      = '0;
        cnt_nxt      = DIV_STEPS_DERIV;
        state_nxt    = ST_DIV_DERIV;
      end
      ST_DIV_DERIV, ST_DIV_ACCEL: begin
        rem_nxt = div_ge ? 16'(rem_sh - {1'b0, dt_r}) : rem_sh[15:0];
        quo_nxt = {quo_r[DIV_W-2:0], div_ge};
        num_nxt = {num_r[DIV_W-2:0], 1'b0};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          state_nxt = (state_r == ST_DIV_DERIV) ? ST_MUL_P : ST_ACC_CLAMP;
        end
      end
      ST_MUL_P: begin
        mul_a     = $signed({1'b0, gain_p_r});
        mul_b     = MUL_BW'(err_r);
        prod_nxt  = mul_p;
        state_nxt = ST_MUL_I;
      end
      ST_MUL_I: begin
        pid_nxt   = PID_W'(prod_r);
        mul_a     = $signed({1'b0, gain_i_r});
        mul_b     = MUL_BW'(err_sum_r);
        prod_nxt  = mul_p;
        state_nxt = ST_MUL_D;
      end
      ST_MUL_D: begin
        pid_nxt   = pid_r + PID_W'(prod_r);
        mul_a     = $signed({1'b0, gain_d_r});
        mul_b     = deriv;
        prod_nxt  = mul_p;
        state_nxt = ST_ADD_PID;
      end
      ST_ADD_PID: begin
        pid_nxt   = pid_r + PID_W'(prod_r);
        state_nxt = ST_UPD_DES;
      end
      ST_UPD_DES: begin
        sat_res   = sat32(SUM_W'(des_r) + SUM_W'(pid_r >>> FRAC_BITS));
        des_nxt   = sat_res.val;
        sat_nxt   = sat_r | sat_res.sat;
        state_nxt = ST_ACC_DIFF;
      end
      ST_ACC_DIFF: begin
        if (limit_en_r) begin
          diff_nxt  = 34'(des_r) - 34'(meas_r);
          state_nxt = ST_ACC_CHK;
        end else begin
          lin_nxt   = 34'(des_r);
          state_nxt = ST_FIN;
        end
      end
      ST_ACC_CHK: begin
        div_neg_nxt = diff_r[33];
        // quotient reaches 2^15 exactly when 2*|diff| >= dt: clamp right away
        if ({diff_mag, 1'b0} >= 35'(dt_r)) begin
          acc_nxt   = diff_r[33] ? acc_lo : acc_hi;
          state_nxt = ST_MUL_ACC;
        end else begin
          rem_nxt   = diff_mag[15:0];
          num_nxt   = '0;
          quo_nxt   = '0;
          cnt_nxt   = DIV_STEPS_ACCEL;
          state_nxt = ST_DIV_ACCEL;
        end
      end
      ST_ACC_CLAMP: begin
        if (acc_q > acc_hi) begin
          acc_nxt = acc_hi;
        end else if (acc_q < acc_lo) begin
          acc_nxt = acc_lo;
        end else begin
          acc_nxt = acc_q;
        end
        state_nxt = ST_MUL_ACC;
      end
      ST_MUL_ACC: begin
        mul_a     = acc_r;
        mul_b     = MUL_BW'({1'b0, dt_r});
        prod_nxt  = mul_p;
        state_nxt = ST_LIN;
      end
      ST_LIN: begin
        lin_nxt   = 34'(meas_r) + 34'(prod_r >>> 16);
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.linear_command  = lin_out;
          out_nxt.angular_command = turn_r;
          out_nxt.saturated       = sat_r | lin_sat;
          out_valid_nxt           = 1'b1;
          state_nxt               = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      err_sum_r   <= '0;
      prev_err_r  <= '0;
      des_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      err_sum_r   <= err_sum_nxt;
      prev_err_r  <= prev_err_nxt;
      des_r       <= des_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r     <= out_nxt;
    err_r     <= err_nxt;
    turn_r    <= turn_nxt;
    meas_r    <= meas_nxt;
    dt_r      <= dt_nxt;
    sat_r     <= sat_nxt;
    prod_r    <= prod_nxt;
    pid_r     <= pid_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    num_r     <= num_nxt;
    cnt_r     <= cnt_nxt;
    div_neg_r <= div_neg_nxt;
    diff_r    <= diff_nxt;
    acc_r     <= acc_nxt;
    lin_r     <= lin_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r   <= RST_GAIN_P;
      gain_i_r   <= RST_GAIN_I;
      gain_d_r   <= RST_GAIN_D;
      max_lin_r  <= RST_MAX_LINEAR;
      max_turn_r <= RST_MAX_TURN;
      max_acc_r  <= RST_MAX_ACCEL;
      max_dec_r  <= RST_MAX_DECEL;
      limit_en_r <= RST_LIMIT_EN;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_GAIN_P:     gain_p_r   <= cfg_wdata;
        REG_GAIN_I:     gain_i_r   <= cfg_wdata;
        REG_GAIN_D:     gain_d_r   <= cfg_wdata;
        REG_MAX_LINEAR: max_lin_r  <= cfg_wdata[14:0];
        REG_MAX_TURN:   max_turn_r <= cfg_wdata[14:0];
        REG_MAX_ACCEL:  max_acc_r  <= cfg_wdata[14:0];
        REG_MAX_DECEL:  max_dec_r  <= cfg_wdata[14:0];
        REG_LIMIT_EN:   limit_en_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // divider remainder stays below the divisor
  a_rem_below_dt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_DERIV || state_r == ST_DIV_ACCEL) |-> ({1'b0, rem_r} < {1'b0, dt_r}))
    else $error("divider remainder not below time step");

  // zero time step was replaced by one
  a_dt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (dt_r != 16'd0))
    else $error("time step of zero reached the datapath");

  // acceleration inside its clamp before scaling by dt
  a_acc_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL_ACC) |-> (acc_r <= acc_hi && acc_r >= acc_lo))
    else $error("acceleration outside clamp");

  // a delivered linear command never exceeds the cap
  a_lin_capped: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (17'(out_r.linear_command) <= $signed({2'b00, max_lin_r})))
    else $error("linear command above cap");

endmodule

// File: verif/tb_velocity_pid_accel_limited.sv
`timescale 1ns / 1ps

module tb_velocity_pid_accel_limited;
  import vpid_pkg::*;

  localparam int RESET_CYCLES  = 11;
  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 240;
  localparam int BURST_ITEMS   = 12;

  localparam longint ACC_HI = 64'sd2147483647;
  localparam longint ACC_LO = -64'sd2147483648;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  // Predictor copy of the register file
  logic [15:0] kp_gain;
  logic [15:0] ki_gain;
  logic [15:0] kd_gain;
  logic [14:0] lin_cap;
  logic [14:0] turn_cap;
  logic [14:0] accel_cap;
  logic [14:0] decel_cap;
  logic        limit_on;

  // Predictor copy of the controller state
  int          err_integral = 0;
  int          last_error = 0;
  int          speed_setpoint = 0;

  out_t        pending_commands[$];
  int          fail_count = 0;
  int          idle_cycles;
  bit          no_idle;
  // number of long receiver holds asked for so far
  int          hold_request;

  velocity_pid_accel_limited dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // One control tick; updates the integral, last error and setpoint
  function automatic out_t predict_command(in_t tick);
    longint target;
    longint turn;
    longint meas;
    longint step;
    longint raw;
    longint err;
    longint deriv;
    longint pid;
    longint accel;
    longint lin;
    bit     sat;
    out_t   cmd;
    target = longint'($signed(tick.target_speed));
    turn   = longint'($signed(tick.target_turn));
    meas   = longint'($signed(tick.measured_speed));
    step   = longint'(tick.time_step);
    if (step == 0) step = 1;
    if (target < 0) target = -target;

    raw = target - meas;
    err = clip(raw, -65536, 65535);
    sat = (err != raw);

    raw = longint'(err_integral) + ((err * step) >>> 16);
    err_integral = int'(clip(raw, ACC_LO, ACC_HI));
    sat |= (longint'(err_integral) != raw);

    // division by the time step truncates toward zero
    deriv = ((err - longint'(last_error)) * 65536) / step;
    last_error = int'(err);

    pid = longint'(kp_gain) * err + longint'(ki_gain) * longint'(err_integral)
        + longint'(kd_gain) * deriv;
    pid = pid >>> FRAC_BITS;

    raw = longint'(speed_setpoint) + pid;
    speed_setpoint = int'(clip(raw, ACC_LO, ACC_HI));
    sat |= (longint'(speed_setpoint) != raw);

    if (limit_on) begin
      accel = ((longint'(speed_setpoint) - meas) * 65536) / step;
      if (accel > longint'(accel_cap)) accel = longint'(accel_cap);
      else if (accel < -longint'(decel_cap)) accel = -longint'(decel_cap);
      lin = meas + ((accel * step) >>> 16);
    end else begin
      lin = longint'(speed_setpoint);
    end

    if (lin > longint'(lin_cap)) lin = longint'(lin_cap);
    raw = lin;
    lin = clip(raw, -32768, 32767);
    sat |= (lin != raw);

    if (turn > longint'(turn_cap)) turn = longint'(turn_cap);
    if (turn < -longint'(turn_cap)) turn = -longint'(turn_cap);

    cmd.linear_command  = lin[15:0];
    cmd.angular_command = turn[15:0];
    cmd.saturated       = sat;
    return cmd;
  endfunction

  function automatic in_t make_tick(int tgt, int turn, int meas, int step);
    in_t tick;
    tick.target_speed   = tgt[15:0];
    tick.target_turn    = turn[15:0];
    tick.measured_speed = meas[15:0];
    tick.time_step      = step[15:0];
    return tick;
  endfunction

  // Plausible control ticks most of the time, raw noise otherwise
  function automatic in_t random_tick(bit well_formed);
    int mag;
    int tgt;
    int meas;
    int turn;
    int step;
    if (!well_formed) return make_tick($urandom, $urandom, $urandom, $urandom);
    mag  = $urandom_range(0, 2048);
    tgt  = ($urandom_range(0, 1) == 1) ? -mag : mag;
    meas = mag + int'($urandom_range(0, 512)) - 256;
    turn = int'($urandom_range(0, 4096)) - 2048;
    step = ($urandom_range(0, 31) == 0) ? 0 : $urandom_range(300, 7000);
    return make_tick(tgt, turn, meas, step);
  endfunction

  function automatic logic [15:0] pick_gain(int kind);
    case (kind)
      0: return 16'($urandom_range(0, 512));
      1: return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Top bit is junk on purpose: the register keeps only 15 bits
  function automatic logic [15:0] pick_cap();
    logic [14:0] cap;
    case ($urandom_range(0, 5))
      0: cap = '0;
      1: cap = '1;
      2: cap = 15'($urandom);
      default: cap = 15'($urandom_range(0, 4096));
    endcase
    return {($urandom_range(0, 1) == 1), cap};
  endfunction

  task automatic check_field(string field, logic signed [16:0] want,
                             logic signed [16:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_commands.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %0d %0d %0b", $time,
                   out_data.linear_command, out_data.angular_command, out_data.saturated);
          fail_count++;
        end else begin
          want = pending_commands.pop_front();
          check_field("linear_command", 17'(want.linear_command),
                      17'(out_data.linear_command));
          check_field("angular_command", 17'(want.angular_command),
                      17'(out_data.angular_command));
          check_field("saturated", 17'(want.saturated), 17'(out_data.saturated));
        end
      end
      if (in_valid && in_ready) pending_commands.push_back(predict_command(in_data));
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : result_sink
    int unsigned pause;
    int          holds_served;
    holds_served = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request != holds_served) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_served = hold_request;
      end
      pause = no_idle ? 0 : $urandom_range(0, 4);
      if (pause != 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready) && hold_request == holds_served);
    end
  end

  // Offer one tick; returns at the edge where the tick is accepted
  task automatic send_tick(in_t tick);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= tick;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_commands.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_GAIN_P:     kp_gain   = value;
      REG_GAIN_I:     ki_gain   = value;
      REG_GAIN_D:     kd_gain   = value;
      REG_MAX_LINEAR: lin_cap   = value[14:0];
      REG_MAX_TURN:   turn_cap  = value[14:0];
      REG_MAX_ACCEL:  accel_cap = value[14:0];
      REG_MAX_DECEL:  decel_cap = value[14:0];
      REG_LIMIT_EN:   limit_on  = value[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
                                logic [15:0] lin, logic [15:0] turn, logic [15:0] acc,
                                logic [15:0] dec, logic [15:0] en);
    wait_drained();
    write_reg(REG_GAIN_P, kp);
    write_reg(REG_GAIN_I, ki);
    write_reg(REG_GAIN_D, kd);
    write_reg(REG_MAX_LINEAR, lin);
    write_reg(REG_MAX_TURN, turn);
    write_reg(REG_MAX_ACCEL, acc);
    write_reg(REG_MAX_DECEL, dec);
    write_reg(REG_LIMIT_EN, en);
  endtask

  task automatic test_directed();
    // defaults after reset: zero time step, error clipping, turn clamp both ways
    send_tick(make_tick(0, 0, 0, 0));
    send_tick(make_tick(256, 100, 0, 655));
    send_tick(make_tick(-256, -100, 0, 655));
    send_tick(make_tick(-32768, 32767, -32768, 65535));
    send_tick(make_tick(32767, -32768, 32767, 1));
    send_tick(make_tick(0, 0, -32768, 65535));
    send_tick(make_tick(0, -512, 32767, 0));

    // full gains, no accel limit: setpoint runs into both rails
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
    send_tick(make_tick(32767, 513, -32768, 1));
    send_tick(make_tick(0, -513, 32767, 1));
    send_tick(make_tick(-32768, 0, -32768, 65535));
    send_tick(make_tick(0, 0, 0, 65535));
    send_tick(make_tick(100, 0, 100, 0));

    // caps written with only the dropped bit set, so they read as zero
    apply_settings(0, 0, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF);
    send_tick(make_tick(1000, 1, 0, 655));
    send_tick(make_tick(-1000, -1, 500, 65535));
    send_tick(make_tick(0, 32767, -32768, 1));

    apply_settings(256, 16, 64, 16'hFFFF, 1024, 16'h7FFF, 0, 1);
    send_tick(make_tick(2048, 1024, 0, 6554));
    send_tick(make_tick(2048, -2048, 1024, 0));
    send_tick(make_tick(-2048, 0, 4096, 65535));
    send_tick(make_tick(0, 0, -32768, 6554));
  endtask

  // Receiver holds off while ticks keep coming, so the input side stalls
  task automatic test_backpressure();
    apply_settings(128, 4, 8, 4096, 1024, 512, 512, 1);
    hold_request++;
    for (int i = 0; i < BURST_ITEMS; i++) send_tick(random_tick(1'b1));
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apply_settings(pick_gain(p % 4), pick_gain(p % 4), pick_gain(p % 4), pick_cap(),
                     pick_cap(), pick_cap(), pick_cap(), 16'(p % 2));
      no_idle = (p % 3 == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) send_tick(random_tick($urandom_range(0, 3) != 0));
    end
    no_idle = 1'b0;
  endtask

  initial begin
    in_valid     <= 1'b0;
    in_data      <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_GAIN_P;
    cfg_wdata    <= '0;
    rst_n        <= 1'b0;
    kp_gain        = 16'd128;
    ki_gain        = 16'd0;
    kd_gain        = 16'd0;
    lin_cap        = 15'd256;
    turn_cap       = 15'd512;
    accel_cap      = 15'd26;
    decel_cap      = 15'd26;
    limit_on       = 1'b1;
    no_idle        = 1'b0;
    hold_request   = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random_phases();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/vpid_pkg.sv
hdl/velocity_pid_accel_limited.sv
verif/tb_velocity_pid_accel_limited.sv
